FILE: rtl/core/fwcp_pkg.sv
// ----------------------------------------------------------------------------
// fwcp_pkg
// Shared types and constants for the flash write command planner: request
// and command payload structs, flash opcodes and controller/datapath links.
// ----------------------------------------------------------------------------
package fwcp_pkg;

    // flash command bytes
    localparam logic [7:0] OP_ERASE   = 8'h20;
    localparam logic [7:0] OP_PROGRAM = 8'h02;

    // command limit per request and the width of its counter
    localparam int unsigned MAX_RESULTS = 19;
    localparam int unsigned K_W         = 5;

    // write request
    typedef struct packed {
        logic [23:0] start_address;
        logic [12:0] byte_length;
    } t_in_item;

    // one planned flash command
    typedef struct packed {
        logic [7:0]  opcode;
        logic [23:0] flash_address;
        logic [8:0]  program_count;
        logic [11:0] buffer_offset;
        logic        last_command;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic erase;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic len_zero;
        logic sec_last;
        logic cmd_last;
        logic out_free;
    } t_status;

endpackage

FILE: rtl/core/fwcp_dpath.sv
// ----------------------------------------------------------------------------
// fwcp_dpath
// Address, length, sector and offset registers of the planner, the page
// split arithmetic and the registered command output.
// ----------------------------------------------------------------------------
module fwcp_dpath import fwcp_pkg::*; #(
    parameter int unsigned SECTOR_BYTES = 4096,
    parameter int unsigned PAGE_BYTES   = 256,
    parameter int unsigned MAX_LEN      = 4096
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_data,
    input  t_cmd      i_cmd,
    output t_status   o_status,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    localparam int unsigned SEC_LOG = $clog2(SECTOR_BYTES);
    localparam int unsigned PG_LOG  = $clog2(PAGE_BYTES);
    localparam int unsigned LEN_W   = $clog2(MAX_LEN + 1);
    localparam int unsigned SUM_W   = ((SEC_LOG > LEN_W) ? SEC_LOG : LEN_W) + 1;
    localparam int unsigned NS_W    = SUM_W - SEC_LOG + 1;
    localparam int unsigned CMP_W   = ((PG_LOG + 1) > LEN_W) ? (PG_LOG + 1) : LEN_W;

    logic [23:0]      r_addr;
    logic [LEN_W-1:0] r_len;
    logic [23:0]      r_sec_addr;
    logic [NS_W-1:0]  r_sec_left;
    logic [LEN_W-1:0] r_off;
    logic [K_W-1:0]   r_k;
    logic             r_out_valid;
    t_out_item        r_out_data;

    logic             in_len_big;
    logic [LEN_W-1:0] in_len;
    logic [SUM_W-1:0] sec_sum;
    logic [CMP_W-1:0] room;
    logic [CMP_W-1:0] len_ext;
    logic [CMP_W-1:0] n_cnt;
    logic             k_last;
    logic             page_last;
    logic             out_free;
    t_out_item        n_out_data;

    // length saturation and sector span of a new request
    assign in_len_big = {1'b0, i_in_data.byte_length} > 14'(MAX_LEN);
    assign in_len     = in_len_big ? LEN_W'(MAX_LEN) : LEN_W'(i_in_data.byte_length);
    assign sec_sum    = SUM_W'(i_in_data.start_address[SEC_LOG-1:0]) + SUM_W'(in_len)
                        - SUM_W'(1);

    // bytes left in the current page against bytes left in the request
    assign room      = CMP_W'(PAGE_BYTES) - CMP_W'(r_addr[PG_LOG-1:0]);
    assign len_ext   = CMP_W'(r_len);
    assign n_cnt     = (room < len_ext) ? room : len_ext;
    assign k_last    = (r_k == K_W'(MAX_RESULTS - 1));
    assign page_last = (len_ext <= room);

    assign out_free = !r_out_valid || !i_out_stall;

    // status to the controller
    assign o_status.len_zero = (i_in_data.byte_length == 13'd0);
    assign o_status.sec_last = (r_sec_left == NS_W'(1));
    assign o_status.cmd_last = i_cmd.erase ? k_last : (k_last || page_last);
    assign o_status.out_free = out_free;

    // command built from the current registers
    always_comb begin
        if (i_cmd.erase) begin
            n_out_data.opcode        = OP_ERASE;
            n_out_data.flash_address = r_sec_addr;
            n_out_data.program_count = 9'd0;
            n_out_data.buffer_offset = 12'd0;
            n_out_data.last_command  = k_last;
        end else begin
            n_out_data.opcode        = OP_PROGRAM;
            n_out_data.flash_address = r_addr;
            n_out_data.program_count = 9'(n_cnt);
            n_out_data.buffer_offset = 12'(r_off);
            n_out_data.last_command  = k_last || page_last;
        end
    end

    // request progress registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addr     <= i_in_data.start_address;
            r_len      <= in_len;
            r_sec_addr <= i_in_data.start_address & ~24'(SECTOR_BYTES - 1);
            r_sec_left <= NS_W'(sec_sum >> SEC_LOG) + NS_W'(1);
            r_off      <= '0;
            r_k        <= '0;
        end else if (i_cmd.step) begin
            r_k <= r_k + K_W'(1);
            if (i_cmd.erase) begin
                r_sec_addr <= r_sec_addr + 24'(SECTOR_BYTES);
                r_sec_left <= r_sec_left - NS_W'(1);
            end else begin
                r_addr <= r_addr + 24'(n_cnt);
                r_len  <= r_len - LEN_W'(n_cnt);
                r_off  <= r_off + LEN_W'(n_cnt);
            end
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: rtl/core/fwcp_ctrl.sv
// ----------------------------------------------------------------------------
// fwcp_ctrl
// Sequencer of the planner: takes a request, walks the erase phase and then
// the program phase, one command per free output slot.
// ----------------------------------------------------------------------------
module fwcp_ctrl import fwcp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ERASE,
        ST_PROG
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;
    logic   step;

    assign accept = i_in_valid && (r_state == ST_IDLE);
    assign step   = (r_state != ST_IDLE) && i_status.out_free;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cmd.load  = accept;
    assign o_cmd.step  = step;
    assign o_cmd.erase = (r_state == ST_ERASE);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && !i_status.len_zero) begin
                    n_state = ST_ERASE;
                end
            end
            ST_ERASE: begin
                if (step) begin
                    if (i_status.cmd_last) begin
                        n_state = ST_IDLE;
                    end else if (i_status.sec_last) begin
                        n_state = ST_PROG;
                    end
                end
            end
            ST_PROG: begin
                if (step && i_status.cmd_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/core/flash_write_command_planner_core.sv
// ----------------------------------------------------------------------------
// flash_write_command_planner_core
// Plans the serial NOR flash commands for one write request: sector erases
// for every sector touched, then page programs split at page boundaries.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (i_in_valid, i_in_data, o_in_stall) carries one write
//   request: start address and byte length. Output channel (o_out_valid,
//   o_out_data, i_out_stall) carries the planned commands in order, the
//   erases first, then the page programs; last_command marks the final one.
//   A request is taken only while the planner is idle; o_in_stall is high
//   from the cycle after a request until its last command is registered.
//   A taken request loads the datapath registers and the sequencer enters
//   the erase phase; the first command is then registered at the output,
//   and further commands follow one per cycle while the output is not
//   stalled. A zero-length request produces nothing. The rate is set by
//   the sequencer, which issues one command per cycle into the single
//   output register while it is free. When the receiver stalls, the
//   registered command holds and the planner pauses. Reset returns the
//   sequencer to idle and empties the output.
// ----------------------------------------------------------------------------
module flash_write_command_planner_core import fwcp_pkg::*; #(
    parameter int unsigned SECTOR_BYTES = 4096,
    parameter int unsigned PAGE_BYTES   = 256,
    parameter int unsigned MAX_LEN      = 4096
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    t_cmd    cmd;
    t_status status;

    // sequencer
    fwcp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // address and length datapath
    fwcp_dpath #(
        .SECTOR_BYTES (SECTOR_BYTES),
        .PAGE_BYTES   (PAGE_BYTES),
        .MAX_LEN      (MAX_LEN)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

FILE: verif/flash_write_command_planner_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flash_write_command_planner_core_tb
// Sends write requests to the planner and checks every command it issues
// against a predicted plan. The plan has the sector erases first, then the
// page programs. A directed table comes first, with corner cases, then
// random requests. Both sides idle at random, and the receiver twice holds
// off for a long stretch.
// ----------------------------------------------------------------------------
module flash_write_command_planner_core_tb;
    import fwcp_pkg::*;

    // flash geometry, same as the block defaults
    localparam int unsigned SECTOR_BYTES = 4096;
    localparam int unsigned PAGE_BYTES   = 256;
    localparam int unsigned MAX_LEN      = 4096;

    localparam int RANDOM_ITEMS   = 200;
    localparam int LONG_HOLD      = 150;
    localparam int DRAIN_CYCLES   = 25;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PREDICTED      = -1;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    t_in_item  i_in_data;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;
    logic      i_out_stall;

    // commands still owed by the planner, oldest first
    t_out_item planned_cmds [$];
    int        errors        = 0;
    int        quiet_cycles  = 0;
    int        holds_asked   = 0;
    int        holds_done    = 0;
    bit        sender_calm   = 1'b0;
    bit        receiver_calm = 1'b0;

    // directed request; typed_count of PREDICTED leaves the plan to the predictor
    typedef struct {
        t_in_item  req;
        int        typed_count;
        t_out_item typed_first;
        t_out_item typed_second;
    } t_directed_row;

    t_directed_row directed_rows [16] = '{
        // zero length, no commands
        '{'{24'h000000, 13'd0}, 0, '0, '0},
        '{'{24'hABCDEF, 13'd0}, 0, '0, '0},
        // single byte at the bottom and at the top of flash
        '{'{24'h000000, 13'd1}, 2,
          '{OP_ERASE,   24'h000000, 9'd0, 12'd0, 1'b0},
          '{OP_PROGRAM, 24'h000000, 9'd1, 12'd0, 1'b1}},
        '{'{24'hFFFFFF, 13'd1}, 2,
          '{OP_ERASE,   24'hFFF000, 9'd0, 12'd0, 1'b0},
          '{OP_PROGRAM, 24'hFFFFFF, 9'd1, 12'd0, 1'b1}},
        // full length, aligned and unaligned (most commands)
        '{'{24'h000000, 13'd4096}, PREDICTED, '0, '0},
        '{'{24'h000001, 13'd4096}, PREDICTED, '0, '0},
        // overlong lengths saturate
        '{'{24'h123456, 13'h1FFF}, PREDICTED, '0, '0},
        '{'{24'h000100, 13'd4097}, PREDICTED, '0, '0},
        // ranges that run past the top of flash
        '{'{24'hFFFF80, 13'd512},  PREDICTED, '0, '0},
        '{'{24'hFFFFFF, 13'd4096}, PREDICTED, '0, '0},
        // page and sector crossings, and one exact page
        '{'{24'h0000FF, 13'd2},    PREDICTED, '0, '0},
        '{'{24'h000FFF, 13'd2},    PREDICTED, '0, '0},
        '{'{24'h000200, 13'd256},  PREDICTED, '0, '0},
        '{'{24'h555555, 13'h0AAA}, PREDICTED, '0, '0},
        '{'{24'hAAAAAA, 13'h1555}, PREDICTED, '0, '0},
        '{'{24'h7FF000, 13'd4095}, PREDICTED, '0, '0}
    };

    flash_write_command_planner_core #(
        .SECTOR_BYTES(SECTOR_BYTES),
        .PAGE_BYTES  (PAGE_BYTES),
        .MAX_LEN     (MAX_LEN)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data),
        .i_out_stall(i_out_stall)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // erases for every touched sector, then programs split at page edges
    task automatic plan_write(input t_in_item req);
        t_out_item   cmds [MAX_RESULTS];
        logic [23:0] addr;
        logic [23:0] sec_addr;
        int unsigned len;
        int unsigned nsec;
        int unsigned room;
        int unsigned n;
        int unsigned off;
        int unsigned k;
        len = 32'(req.byte_length);
        if (len > MAX_LEN) len = MAX_LEN;
        if (len == 0) return;
        addr     = req.start_address;
        k        = 0;
        nsec     = ((addr % SECTOR_BYTES) + len - 1) / SECTOR_BYTES + 1;
        sec_addr = 24'(addr - (addr % SECTOR_BYTES));
        for (int s = 0; s < nsec && k < MAX_RESULTS; s++) begin
            cmds[k]  = '{OP_ERASE, sec_addr, 9'd0, 12'd0, 1'b0};
            k++;
            sec_addr = 24'(sec_addr + SECTOR_BYTES);
        end
        off = 0;
        while (len > 0 && k < MAX_RESULTS) begin
            room    = PAGE_BYTES - (addr % PAGE_BYTES);
            n       = (room < len) ? room : len;
            cmds[k] = '{OP_PROGRAM, addr, n[8:0], off[11:0], 1'b0};
            k++;
            addr = 24'(addr + n);
            off  = off + n;
            len  = len - n;
        end
        cmds[k-1].last_command = 1'b1;
        for (int i = 0; i < k; i++) planned_cmds.push_back(cmds[i]);
    endtask

    // mostly short writes, some up to full length and some overlong, addresses biased to edges
    function automatic t_in_item random_request();
        t_in_item req;
        int       kind;
        kind              = $urandom_range(0, 9);
        req.start_address = 24'($urandom);
        case ($urandom_range(0, 3))
            0: req.start_address = 24'(24'hFFFFFF - $urandom_range(0, 700));
            1: req.start_address[7:0] = 8'h00;
            default: ;
        endcase
        case (kind)
            0:       req.byte_length = 13'd0;
            1:       req.byte_length = 13'($urandom_range(MAX_LEN + 1, 8191));
            2, 3:    req.byte_length = 13'($urandom_range(1, MAX_LEN));
            default: req.byte_length = 13'($urandom_range(1, 600));
        endcase
        return req;
    endfunction

    // offer one request after a random gap and wait until the planner is idle again
    task automatic send_request(input t_in_item req);
        int gap;
        if ($urandom_range(0, 15) == 0) sender_calm = !sender_calm;
        gap = sender_calm ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic check_command(input t_out_item want, input t_out_item got);
        if (got.opcode !== want.opcode) begin
            $error("opcode: expected %h, got %h", want.opcode, got.opcode);
            errors++;
        end
        if (got.flash_address !== want.flash_address) begin
            $error("flash_address: expected %h, got %h",
                   want.flash_address, got.flash_address);
            errors++;
        end
        if (got.program_count !== want.program_count) begin
            $error("program_count: expected %0d, got %0d",
                   want.program_count, got.program_count);
            errors++;
        end
        if (got.buffer_offset !== want.buffer_offset) begin
            $error("buffer_offset: expected %0d, got %0d",
                   want.buffer_offset, got.buffer_offset);
            errors++;
        end
        if (got.last_command !== want.last_command) begin
            $error("last_command: expected %b, got %b",
                   want.last_command, got.last_command);
            errors++;
        end
    endtask

    // request side: reset, directed table, random requests, drain
    initial begin
        t_in_item req;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            send_request(directed_rows[r].req);
            if (directed_rows[r].typed_count == PREDICTED) begin
                plan_write(directed_rows[r].req);
            end else begin
                if (directed_rows[r].typed_count > 0)
                    planned_cmds.push_back(directed_rows[r].typed_first);
                if (directed_rows[r].typed_count > 1)
                    planned_cmds.push_back(directed_rows[r].typed_second);
            end
        end

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 60 || i == 150) holds_asked++;
            req = random_request();
            send_request(req);
            plan_write(req);
        end
        i_in_valid <= 1'b0;

        while (planned_cmds.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (planned_cmds.size() != 0) begin
            $error("%0d commands never issued", planned_cmds.size());
            errors++;
        end
        if (errors == 0)
            $display("flash_write_command_planner_core_tb: clean");
        else
            $display("flash_write_command_planner_core_tb: errors");
        $finish;
    end

    // command side: random stalls per command, long hold-off on demand
    initial begin
        int n;
        i_out_stall = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (holds_asked != holds_done) begin
                holds_done++;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            if ($urandom_range(0, 15) == 0) receiver_calm = !receiver_calm;
            n = receiver_calm ? 0 : $urandom_range(0, 7);
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    // compare each issued command with the oldest planned one
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (planned_cmds.size() == 0) begin
                $error("command %h issued with nothing planned", o_out_data);
                errors++;
            end else begin
                check_command(planned_cmds.pop_front(), o_out_data);
            end
        end
    end

    // watchdog on cycles with no request or command taken
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("flash_write_command_planner_core_tb: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

FILE: files.f
rtl/core/fwcp_pkg.sv
rtl/core/fwcp_dpath.sv
rtl/core/fwcp_ctrl.sv
rtl/core/flash_write_command_planner_core.sv
verif/flash_write_command_planner_core_tb.sv
